// ----- hdl/ihpq_pkg.sv -----
`timescale 1ns / 1ps

package ihpq_pkg;

    localparam int CAPACITY_DEF = 255;
    localparam int HANDLE_W     = 8;
    localparam int HANDLES      = 1 << HANDLE_W;
    localparam int PRI_W        = 31;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 96;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SWITCH = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REFUSED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DISABLED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_EN   = 1'd1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                tag;
        logic [PRI_W-1:0]    pri;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DECODE, S_GONE, S_TAKE, S_TAKE2, S_CHANGE, S_UP,
        S_UP_CMP, S_DN, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_TOP, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_READ, CMD_DECODE, CMD_GONE, CMD_TAKE, CMD_TAKE2,
        CMD_CHANGE, CMD_UP, CMD_UP_CMP, CMD_DN, CMD_DN_L, CMD_DN_R, CMD_DN_CMP,
        CMD_PLACE, CMD_TOP, CMD_RESULT
    } cmd_t;

    typedef enum logic [2:0] {
        RT_DONE, RT_CHANGE, RT_INSERT, RT_TAKE, RT_REMOVE
    } route_t;

    typedef struct packed {
        route_t route;
        logic   below;
        logic   last;
        logic   root;
        logic   leaf;
        logic   has_right;
        logic   out_busy;
    } dp_stat_t;

    function automatic logic ranks_below(slot_t a, slot_t b, logic en, logic desc,
                                         logic serving);
        logic res;
        if (en) begin
            if (a.tag == b.tag) begin
                res = desc ? (a.pri < b.pri) : (a.pri > b.pri);
            end else begin
                res = (a.tag != serving);
            end
        end else begin
            res = desc ? ({a.tag, a.pri} < {b.tag, b.pri})
                       : ({a.tag, a.pri} > {b.tag, b.pri});
        end
        return res;
    endfunction

endpackage

// ----- hdl/ihpq_ctrl.sv -----
`timescale 1ns / 1ps

module ihpq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ihpq_pkg::dp_stat_t  stat,
    output ihpq_pkg::cmd_t      cmd
);

    ihpq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ihpq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ihpq_pkg::S_IDLE: begin
                if (s_tvalid) state_next = ihpq_pkg::S_READ;
            end
            ihpq_pkg::S_READ:   state_next = ihpq_pkg::S_DECODE;
            ihpq_pkg::S_DECODE: begin
                unique case (stat.route)
                    ihpq_pkg::RT_CHANGE: state_next = ihpq_pkg::S_CHANGE;
                    ihpq_pkg::RT_INSERT: state_next = ihpq_pkg::S_UP;
                    ihpq_pkg::RT_TAKE:   state_next = ihpq_pkg::S_TAKE;
                    ihpq_pkg::RT_REMOVE: state_next = ihpq_pkg::S_GONE;
                    default:             state_next = ihpq_pkg::S_TOP;
                endcase
            end
            ihpq_pkg::S_GONE:   state_next = ihpq_pkg::S_TAKE;
            ihpq_pkg::S_TAKE:   state_next = stat.last ? ihpq_pkg::S_TOP : ihpq_pkg::S_TAKE2;
            ihpq_pkg::S_TAKE2:  state_next = stat.below ? ihpq_pkg::S_UP : ihpq_pkg::S_DN;
            ihpq_pkg::S_CHANGE: state_next = stat.below ? ihpq_pkg::S_UP : ihpq_pkg::S_DN;
            ihpq_pkg::S_UP:     state_next = stat.root ? ihpq_pkg::S_PLACE : ihpq_pkg::S_UP_CMP;
            ihpq_pkg::S_UP_CMP: state_next = stat.below ? ihpq_pkg::S_UP : ihpq_pkg::S_PLACE;
            ihpq_pkg::S_DN:     state_next = stat.leaf ? ihpq_pkg::S_PLACE : ihpq_pkg::S_DN_L;
            ihpq_pkg::S_DN_L:   state_next = stat.has_right ? ihpq_pkg::S_DN_R
                                                            : ihpq_pkg::S_DN_CMP;
            ihpq_pkg::S_DN_R:   state_next = ihpq_pkg::S_DN_CMP;
            ihpq_pkg::S_DN_CMP: state_next = stat.below ? ihpq_pkg::S_DN : ihpq_pkg::S_PLACE;
            ihpq_pkg::S_PLACE:  state_next = ihpq_pkg::S_TOP;
            ihpq_pkg::S_TOP:    state_next = ihpq_pkg::S_OUT;
            ihpq_pkg::S_OUT: begin
                if (!stat.out_busy) state_next = ihpq_pkg::S_IDLE;
            end
            default:            state_next = ihpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = ihpq_pkg::CMD_NONE;
        unique case (state_reg)
            ihpq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd = ihpq_pkg::CMD_LOAD;
            end
            ihpq_pkg::S_READ:   cmd = ihpq_pkg::CMD_READ;
            ihpq_pkg::S_DECODE: cmd = ihpq_pkg::CMD_DECODE;
            ihpq_pkg::S_GONE:   cmd = ihpq_pkg::CMD_GONE;
            ihpq_pkg::S_TAKE:   cmd = ihpq_pkg::CMD_TAKE;
            ihpq_pkg::S_TAKE2:  cmd = ihpq_pkg::CMD_TAKE2;
            ihpq_pkg::S_CHANGE: cmd = ihpq_pkg::CMD_CHANGE;
            ihpq_pkg::S_UP:     cmd = ihpq_pkg::CMD_UP;
            ihpq_pkg::S_UP_CMP: cmd = ihpq_pkg::CMD_UP_CMP;
            ihpq_pkg::S_DN:     cmd = ihpq_pkg::CMD_DN;
            ihpq_pkg::S_DN_L:   cmd = ihpq_pkg::CMD_DN_L;
            ihpq_pkg::S_DN_R:   cmd = ihpq_pkg::CMD_DN_R;
            ihpq_pkg::S_DN_CMP: cmd = ihpq_pkg::CMD_DN_CMP;
            ihpq_pkg::S_PLACE:  cmd = ihpq_pkg::CMD_PLACE;
            ihpq_pkg::S_TOP:    cmd = ihpq_pkg::CMD_TOP;
            ihpq_pkg::S_OUT: begin
                if (!stat.out_busy) cmd = ihpq_pkg::CMD_RESULT;
            end
            default:            cmd = ihpq_pkg::CMD_NONE;
        endcase
    end

endmodule

// ----- hdl/ihpq_dp.sv -----
`timescale 1ns / 1ps

module ihpq_dp #(
    parameter int CAPACITY = ihpq_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_write,
    input  logic [ihpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_data,
    input  logic [ihpq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [ihpq_pkg::KIND_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ihpq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [ihpq_pkg::STATUS_W-1:0]      m_tuser,
    input  ihpq_pkg::cmd_t                     cmd,
    output ihpq_pkg::dp_stat_t                 stat
);

    localparam int SW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = CAPACITY + 1;
    localparam int PAD_W = ihpq_pkg::OUT_DATA_W - 90;

    ihpq_pkg::slot_t heap_mem [DEPTH];
    logic [SW-1:0]   soh_mem [ihpq_pkg::HANDLES];
    logic [ihpq_pkg::HANDLES-1:0] soh_vld_reg;

    logic desc_reg, desc_next, en_reg, en_next;
    logic serving_reg, serving_next, upcoming_reg, upcoming_next;
    logic [SW-1:0] total_reg, total_next, pos_reg, pos_next;
    logic [SW:0]   c_reg, c_next;
    logic [ihpq_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [ihpq_pkg::HANDLE_W-1:0] h_reg, h_next, oh_reg, oh_next;
    logic [ihpq_pkg::PRI_W-1:0]    pri_reg, pri_next, opri_reg, opri_next;
    logic [ihpq_pkg::STATUS_W-1:0] status_reg, status_next;
    ihpq_pkg::slot_t mv_reg, mv_next, gone_reg, gone_next, best_reg, best_next;
    ihpq_pkg::slot_t hrd_reg, hw_data, ca, cb, new_mv;
    logic [SW-1:0] soh_rd_reg;
    logic          soh_rv_reg;
    logic          mvalid_reg, mvalid_next;
    logic [ihpq_pkg::OUT_DATA_W-1:0] mtdata_reg, mtdata_next;
    logic [ihpq_pkg::STATUS_W-1:0]   mtuser_reg, mtuser_next;

    logic          hw_en, hr_en, sw_en;
    logic [SW-1:0] hw_addr, hr_addr, sw_data;
    logic [ihpq_pkg::HANDLE_W-1:0] sw_addr;
    logic [SW-1:0] found;
    logic          present, below, has_top;
    logic [SW:0]   c_first, c_right;

    assign found   = soh_rv_reg ? soh_rd_reg : '0;
    assign present = (found != '0) && (found <= total_reg);
    assign below   = ihpq_pkg::ranks_below(ca, cb, en_reg, desc_reg, serving_reg);
    assign has_top = (total_reg != '0);
    assign c_first = {pos_reg, 1'b0};
    assign c_right = c_reg + (SW+1)'(1);
    assign new_mv  = '{handle: hrd_reg.handle, tag: en_reg & hrd_reg.tag, pri: pri_reg};

    always_comb begin
        stat.route     = ihpq_pkg::RT_DONE;
        stat.below     = below;
        stat.last      = (pos_reg == total_reg);
        stat.root      = (pos_reg == SW'(1));
        stat.leaf      = (c_first > {1'b0, total_reg});
        stat.has_right = (c_right <= {1'b0, total_reg});
        stat.out_busy  = mvalid_reg && !m_tready;

        desc_next = desc_reg;  en_next = en_reg;
        serving_next = serving_reg;  upcoming_next = upcoming_reg;
        total_next = total_reg;  pos_next = pos_reg;  c_next = c_reg;
        kind_next = kind_reg;  h_next = h_reg;  pri_next = pri_reg;
        oh_next = oh_reg;  opri_next = opri_reg;  status_next = status_reg;
        mv_next = mv_reg;  gone_next = gone_reg;  best_next = best_reg;
        ca = mv_reg;  cb = best_reg;
        hw_en = 1'b0;  hw_addr = pos_reg;  hw_data = mv_reg;
        hr_en = 1'b0;  hr_addr = SW'(1);
        sw_en = 1'b0;  sw_addr = mv_reg.handle;  sw_data = pos_reg;
        mtdata_next = mtdata_reg;  mtuser_next = mtuser_reg;
        mvalid_next = m_tready ? 1'b0 : mvalid_reg;

        if (cfg_write) begin
            if (cfg_index == ihpq_pkg::REG_DESCENDING) desc_next = cfg_data;
            if (cfg_index == ihpq_pkg::REG_EPOCH_EN)   en_next   = cfg_data;
        end

        unique case (cmd)
            ihpq_pkg::CMD_LOAD: begin
                kind_next   = s_tuser;
                h_next      = s_tdata[7:0];
                pri_next    = s_tdata[38:8];
                status_next = ihpq_pkg::STAT_OK;
                oh_next     = '0;
                opri_next   = '0;
            end
            ihpq_pkg::CMD_READ: begin
                hr_en   = 1'b1;
                hr_addr = SW'(1);
            end
            ihpq_pkg::CMD_DECODE: begin
                if (kind_reg == ihpq_pkg::KIND_INSERT || kind_reg == ihpq_pkg::KIND_CHANGE) begin
                    if (present) begin
                        stat.route = ihpq_pkg::RT_CHANGE;
                        hr_en      = 1'b1;
                        hr_addr    = found;
                        pos_next   = found;
                    end else if (total_reg >= SW'(CAPACITY)) begin
                        status_next = ihpq_pkg::STAT_FULL;
                    end else begin
                        stat.route = ihpq_pkg::RT_INSERT;
                        total_next = total_reg + SW'(1);
                        pos_next   = total_reg + SW'(1);
                        mv_next    = '{handle: h_reg, tag: en_reg & upcoming_reg, pri: pri_reg};
                    end
                end else if (kind_reg == ihpq_pkg::KIND_POP) begin
                    if (!has_top) begin
                        status_next = ihpq_pkg::STAT_EMPTY;
                    end else begin
                        stat.route = ihpq_pkg::RT_TAKE;
                        gone_next  = hrd_reg;
                        oh_next    = hrd_reg.handle;
                        opri_next  = hrd_reg.pri;
                        pos_next   = SW'(1);
                    end
                end else if (kind_reg == ihpq_pkg::KIND_REMOVE) begin
                    if (!present) begin
                        status_next = ihpq_pkg::STAT_EMPTY;
                    end else begin
                        stat.route = ihpq_pkg::RT_REMOVE;
                        hr_en      = 1'b1;
                        hr_addr    = found;
                        pos_next   = found;
                        oh_next    = h_reg;
                    end
                end else if (kind_reg == ihpq_pkg::KIND_SWITCH) begin
                    if (!en_reg) begin
                        status_next = ihpq_pkg::STAT_DISABLED;
                    end else if ((has_top ? hrd_reg.tag : upcoming_reg) == !upcoming_reg) begin
                        status_next = ihpq_pkg::STAT_REFUSED;
                    end else begin
                        serving_next  = upcoming_reg;
                        upcoming_next = !upcoming_reg;
                    end
                end
            end
            ihpq_pkg::CMD_GONE: begin
                gone_next = hrd_reg;
                opri_next = hrd_reg.pri;
            end
            ihpq_pkg::CMD_TAKE: begin
                sw_en   = 1'b1;
                sw_addr = gone_reg.handle;
                sw_data = '0;
                if (pos_reg == total_reg) begin
                    total_next = total_reg - SW'(1);
                end else begin
                    hr_en   = 1'b1;
                    hr_addr = total_reg;
                end
            end
            ihpq_pkg::CMD_TAKE2: begin
                mv_next    = hrd_reg;
                total_next = total_reg - SW'(1);
                ca         = gone_reg;
                cb         = hrd_reg;
            end
            ihpq_pkg::CMD_CHANGE: begin
                mv_next = new_mv;
                ca      = hrd_reg;
                cb      = new_mv;
            end
            ihpq_pkg::CMD_UP: begin
                hr_en   = (pos_reg != SW'(1));
                hr_addr = pos_reg >> 1;
            end
            ihpq_pkg::CMD_UP_CMP: begin
                ca = hrd_reg;
                cb = mv_reg;
                if (below) begin
                    hw_en    = 1'b1;
                    hw_data  = hrd_reg;
                    sw_en    = 1'b1;
                    sw_addr  = hrd_reg.handle;
                    pos_next = pos_reg >> 1;
                end
            end
            ihpq_pkg::CMD_DN: begin
                c_next  = c_first;
                hr_en   = !stat.leaf;
                hr_addr = c_first[SW-1:0];
            end
            ihpq_pkg::CMD_DN_L: begin
                best_next = hrd_reg;
                hr_en     = stat.has_right;
                hr_addr   = c_right[SW-1:0];
            end
            ihpq_pkg::CMD_DN_R: begin
                ca = best_reg;
                cb = hrd_reg;
                if (below) begin
                    best_next = hrd_reg;
                    c_next    = c_right;
                end
            end
            ihpq_pkg::CMD_DN_CMP: begin
                ca = mv_reg;
                cb = best_reg;
                if (below) begin
                    hw_en    = 1'b1;
                    hw_data  = best_reg;
                    sw_en    = 1'b1;
                    sw_addr  = best_reg.handle;
                    pos_next = c_reg[SW-1:0];
                end
            end
            ihpq_pkg::CMD_PLACE: begin
                hw_en = 1'b1;
                sw_en = 1'b1;
            end
            ihpq_pkg::CMD_TOP: begin
                hr_en   = 1'b1;
                hr_addr = SW'(1);
            end
            ihpq_pkg::CMD_RESULT: begin
                mvalid_next = 1'b1;
                mtuser_next = status_reg;
                mtdata_next = {PAD_W'(0), upcoming_reg, serving_reg,
                               has_top ? hrd_reg.tag : upcoming_reg,
                               has_top ? hrd_reg.pri : ihpq_pkg::PRI_W'(0),
                               has_top ? hrd_reg.handle : ihpq_pkg::HANDLE_W'(0),
                               has_top, 8'(total_reg), opri_reg, oh_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_reg     <= 1'b1;
            en_reg       <= 1'b0;
            serving_reg  <= 1'b0;
            upcoming_reg <= 1'b1;
            total_reg    <= '0;
            mvalid_reg   <= 1'b0;
            soh_vld_reg  <= '0;
            soh_rv_reg   <= 1'b0;
        end else begin
            desc_reg     <= desc_next;
            en_reg       <= en_next;
            serving_reg  <= serving_next;
            upcoming_reg <= upcoming_next;
            total_reg    <= total_next;
            mvalid_reg   <= mvalid_next;
            if (sw_en) soh_vld_reg[sw_addr] <= 1'b1;
            soh_rv_reg   <= soh_vld_reg[h_reg];
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        c_reg      <= c_next;
        kind_reg   <= kind_next;
        h_reg      <= h_next;
        pri_reg    <= pri_next;
        oh_reg     <= oh_next;
        opri_reg   <= opri_next;
        status_reg <= status_next;
        mv_reg     <= mv_next;
        gone_reg   <= gone_next;
        best_reg   <= best_next;
        mtdata_reg <= mtdata_next;
        mtuser_reg <= mtuser_next;
    end

    always_ff @(posedge aclk) begin
        if (hw_en) heap_mem[hw_addr] <= hw_data;
        if (hr_en) hrd_reg <= heap_mem[hr_addr];
    end

    always_ff @(posedge aclk) begin
        if (sw_en) soh_mem[sw_addr] <= sw_data;
        soh_rd_reg <= soh_mem[h_reg];
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mtdata_reg;
    assign m_tuser  = mtuser_reg;

endmodule

// ----- hdl/indexed_heap_priority_queue_epoch_core.sv -----
`timescale 1ns / 1ps
// Indexed binary heap priority queue over element handles.
// Input stream (s_): one beat is one operation; s_tuser carries the kind
// (insert, pop, change, remove, epoch switch), s_tdata the handle and priority.
// Output stream (m_): exactly one beat per operation with status in m_tuser and
// the popped or removed entry, entry count, heap top and epochs in m_tdata.
// Config channel (cfg_): index 0 sets descending order, index 1 enables epochs;
// write only while no operation is in flight. cfg_ready is always high.
// One operation is handled at a time. Each heap level that an entry moves on a
// sift up or a sift down lengthens the operation, since the slot memory has a
// single read port; a full 255-entry heap has eight levels.
// The next input beat can be taken in the cycle after the result is written into
// the output register; a stalled m_tready holds the result and stops the engine
// before the next result only.
// Reset (aresetn low, synchronous) empties the queue, sets serving epoch 0,
// upcoming epoch 1, descending order and epochs disabled; the handle table is
// cleared at once by its valid bits, so no clearing pass is needed.
module indexed_heap_priority_queue_epoch_core #(
    parameter int CAPACITY = ihpq_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ihpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ihpq_pkg::IN_DATA_W-1:0]     s_tdata,  // handle, priority_req, pad
    input  logic [ihpq_pkg::KIND_W-1:0]        s_tuser,  // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_handle, out_priority, entry_count, top_valid, top_handle,
    // top_priority, top_epoch, current_epoch, next_epoch, pad
    output logic [ihpq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [ihpq_pkg::STATUS_W-1:0]      m_tuser   // status
);

    ihpq_pkg::cmd_t     cmd;
    ihpq_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ihpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ihpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while an operation is in flight");

    a_top_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47] == (m_tdata[46:39] != 8'd0)))
        else $error("top_valid disagrees with entry_count");

    a_epochs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[88] != m_tdata[89]))
        else $error("serving and upcoming epoch are equal");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[46:39]) <= 32'(CAPACITY)))
        else $error("entry count beyond capacity");
`endif

endmodule
